// ----- hdl/key_debounce_press_classifier_core_assert.svh -----
// Assertion macros shared by the key debounce and press classifier RTL.
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define KDPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdpc assertion failed");
// next-cycle implication, disabled in reset
`define KDPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdpc assertion failed");
`else
`define KDPC_ASSERT_IMPL(label, ante, cons)
`define KDPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/kdpc_pkg.sv -----
// Types and constants for the key debounce and press classifier.
package kdpc_pkg;

  localparam int KEY_BITS  = 8;
  localparam int COUNT_W   = 8;
  localparam int LONG_W    = 7;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef logic [KEY_BITS-1:0] key_t;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;
  localparam logic [1:0] REG_NO_KEY   = 2'd3;

  localparam logic [7:0]        DEBOUNCE_RESET = 8'd4;
  localparam logic [LONG_W-1:0] LONG_RESET     = 7'd75;
  localparam logic [LONG_W-1:0] HOLD_RESET     = 7'd15;
  localparam key_t              NO_KEY_RESET   = KEY_BITS'(255);

  typedef struct packed {
    logic [7:0]        debounce_count;
    logic [LONG_W-1:0] long_count;
    logic [LONG_W-1:0] hold_interval;
    key_t              no_key_code;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_SHORT_UP = 2'h0,
    KIND_LONG     = 2'h1,
    KIND_HOLD     = 2'h2,
    KIND_LONG_UP  = 2'h3
  } kind_t;

  typedef struct packed {
    logic  fire;
    kind_t kind;
    key_t  key;
  } event_t;

endpackage

// ----- hdl/kdpc_cfg_regs.sv -----
// APB-style configuration registers with reset defaults and read-back.
module kdpc_cfg_regs
  import kdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_count <= DEBOUNCE_RESET;
      cfg_r.long_count     <= LONG_RESET;
      cfg_r.hold_interval  <= HOLD_RESET;
      cfg_r.no_key_code    <= NO_KEY_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE: cfg_r.debounce_count <= pwdata[7:0];
        REG_LONG:     cfg_r.long_count     <= pwdata[LONG_W-1:0];
        REG_HOLD:     cfg_r.hold_interval  <= pwdata[LONG_W-1:0];
        REG_NO_KEY:   cfg_r.no_key_code    <= KEY_BITS'(pwdata[7:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE: prdata = DATA_W'(cfg_r.debounce_count);
      REG_LONG:     prdata = DATA_W'(cfg_r.long_count);
      REG_HOLD:     prdata = DATA_W'(cfg_r.hold_interval);
      REG_NO_KEY:   prdata = DATA_W'(cfg_r.no_key_code);
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/kdpc_debounce.sv -----
// Debounce stage: counts repeats of the raw code and adopts the stable key.
module kdpc_debounce
  import kdpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  key_t raw,
  input  cfg_t cfg,
  output key_t stable_key
);

  key_t               prev_r, prev_nxt;
  logic [COUNT_W-1:0] rpt_r, rpt_nxt, rpt_inc;
  key_t               stable_r, stable_nxt;

  always_comb begin
    prev_nxt   = prev_r;
    rpt_nxt    = rpt_r;
    stable_nxt = stable_r;
    rpt_inc    = (rpt_r == COUNT_MAX) ? rpt_r : rpt_r + 1'b1;
    if (raw != prev_r) begin
      rpt_nxt  = '0;
      prev_nxt = raw;
    end else begin
      rpt_nxt = rpt_inc;
      if (rpt_inc == COUNT_W'(cfg.debounce_count)) begin
        stable_nxt = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      rpt_r    <= '0;
      stable_r <= NO_KEY_RESET;
    end else if (step) begin
      prev_r   <= prev_nxt;
      rpt_r    <= rpt_nxt;
      stable_r <= stable_nxt;
    end
  end

  // classifier sees the key as updated by this tick
  assign stable_key = stable_nxt;

endmodule

// ----- hdl/kdpc_classifier.sv -----
// Press classifier: tracks the stable key and decides the event of a tick.
module kdpc_classifier
  import kdpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  key_t   stable_key,
  input  cfg_t   cfg,
  output event_t evt
);

  key_t               last_r, last_nxt;
  logic [COUNT_W-1:0] press_r, press_nxt, press_inc, hold_mark, long_mark;

  assign long_mark = COUNT_W'(cfg.long_count);
  assign hold_mark = long_mark + COUNT_W'(cfg.hold_interval);
  assign press_inc = (press_r == COUNT_MAX) ? press_r : press_r + 1'b1;

  always_comb begin
    last_nxt  = last_r;
    press_nxt = press_r;
    evt.fire  = 1'b0;
    evt.kind  = KIND_SHORT_UP;
    evt.key   = last_r;
    if (stable_key == last_r) begin
      if (stable_key != cfg.no_key_code) begin
        press_nxt = press_inc;
        if (press_inc == long_mark) begin
          evt.fire = 1'b1;
          evt.kind = KIND_LONG;
        end else if (press_inc == hold_mark) begin
          press_nxt = long_mark;
          evt.fire  = 1'b1;
          evt.kind  = KIND_HOLD;
        end
      end
    end else begin
      last_nxt  = stable_key;
      press_nxt = '0;
      if (stable_key == cfg.no_key_code) begin
        evt.fire = 1'b1;
        evt.kind = (press_r >= long_mark) ? KIND_LONG_UP : KIND_SHORT_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= NO_KEY_RESET;
      press_r <= '0;
    end else if (step) begin
      last_r  <= last_nxt;
      press_r <= press_nxt;
    end
  end

endmodule

// ----- hdl/key_debounce_press_classifier_core.sv -----
// Top level of the key debounce and press classifier.
//
// Input channel (in_valid/in_ready/in_raw_key): one raw key sample per scan
// tick. Output channel (out_valid/out_ready/out_event_kind/out_event_key):
// short-up, long, hold and long-up events, each tagged with the key that was
// held. Ticks that cause no event produce no output transaction.
// Configuration: APB-style port, registers at 0x0 debounce count, 0x4 long
// count, 0x8 hold interval, 0xC no-key code; pready is tied high.
//
// Pipeline: an input register, then one pass through debounce and classify
// logic into the output register. An event is written to the output register
// when its tick leaves the input register, and is offered from there.
// Throughput is one tick per cycle, bounded by the single output register:
// a tick leaves the input register only when the output register is empty
// or being emptied.
// When the receiver stalls, the held event stays put, one more tick waits in
// the input register, and in_ready drops until the output drains.
// Reset (rst_n, synchronous, active low) empties both registers, loads the
// register defaults and sets the stable and last keys to 0xFF.
module key_debounce_press_classifier_core
  import kdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_raw_key,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic [7:0]        out_event_key,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

`include "key_debounce_press_classifier_core_assert.svh"

  cfg_t   cfg;
  event_t evt;
  key_t   stable_key;

  // input register
  logic s1_valid_r;
  key_t s1_raw_r;
  logic s1_go;

  // output register
  logic  out_valid_r;
  kind_t out_kind_r;
  key_t  out_key_r;

  // a tick moves on when the output slot is free or is being taken
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw_r <= KEY_BITS'(in_raw_key);
    end
  end

  kdpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kdpc_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .raw        (s1_raw_r),
    .cfg        (cfg),
    .stable_key (stable_key)
  );

  kdpc_classifier u_classifier (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .stable_key (stable_key),
    .cfg        (cfg),
    .evt        (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= evt.fire;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && evt.fire) begin
      out_kind_r <= evt.kind;
      out_key_r  <= evt.key;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_event_key  = 8'(out_key_r);

  // an event never overwrites one still waiting
  `KDPC_ASSERT_IMPL(a_no_overrun, s1_go && evt.fire, !out_valid_r || out_ready)
  // a new tick enters only when the held one leaves
  `KDPC_ASSERT_IMPL(a_room_on_accept, in_valid && in_ready && s1_valid_r, s1_go)
  // output only becomes valid from a tick leaving the input register
  `KDPC_ASSERT_IMPL(a_out_from_stage, $rose(out_valid_r), $past(s1_go))
  // every event belongs to a pressed key
  `KDPC_ASSERT_IMPL(a_event_key_pressed, s1_go && evt.fire, evt.key != cfg.no_key_code)

endmodule
